// ===== hw/rtl/gcs_pkg.sv =====
// Shared types, constants and letter mapping functions for the Gronsfeld
// cipher stream. No dependencies.
package gcs_pkg;

    localparam int unsigned CHAR_W      = 16;
    localparam int unsigned KEY_W       = 64;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned SUM_W       = 7;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    localparam logic [SUM_W-1:0] ALPHA_SIZE = 7'd59;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_DIGITS = 2'd0,
        REG_KEY_LENGTH = 2'd1,
        REG_MODE       = 2'd2
    } cfg_reg_t;

    // One classified character on its way from front to back
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [DIGIT_W-1:0] shift;
        logic               bad;
        logic               eot;
    } entry_t;

    // Alphabet index of a character code; bad set when not a letter
    function automatic logic [IDX_W:0] letter_index(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        begin
            d = '0;
            if (c >= 16'h0410 && c <= 16'h0415)
            begin
                d = c - 16'h0410;
                return {1'b0, d[IDX_W-1:0]};
            end
            else if (c == 16'h0401)
            begin
                return {1'b0, 6'd6};
            end
            else if (c >= 16'h0416 && c <= 16'h042F)
            begin
                d = c - 16'h0416 + 16'd7;
                return {1'b0, d[IDX_W-1:0]};
            end
            else if (c >= 16'h0061 && c <= 16'h007A)
            begin
                d = c - 16'h0061 + 16'd33;
                return {1'b0, d[IDX_W-1:0]};
            end
            return {1'b1, {IDX_W{1'b0}}};
        end
    endfunction

    // Character code of the letter at alphabet index r (r below 59)
    function automatic logic [CHAR_W-1:0] letter_code(input logic [IDX_W-1:0] r);
        logic [CHAR_W-1:0] rw;
        begin
            rw = {{(CHAR_W-IDX_W){1'b0}}, r};
            if (r < 6'd6)
                return 16'h0410 + rw;
            else if (r == 6'd6)
                return 16'h0401;
            else if (r < 6'd33)
                return 16'h0416 + rw - 16'd7;
            return 16'h0061 + rw - 16'd33;
        end
    endfunction

endpackage

// ===== hw/rtl/gcs_front.sv =====
// Front end: accepts characters, classifies them against the alphabet and
// picks the key digit. Depends on gcs_pkg.
module gcs_front #(
    parameter int unsigned MAX_KEY_DIGITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [gcs_pkg::CHAR_W-1:0]     in_code,
    input  logic                           in_last,
    input  logic [gcs_pkg::KEY_W-1:0]      key_digits,
    input  logic [gcs_pkg::LEN_W-1:0]      key_length,
    output logic                           push,
    output gcs_pkg::entry_t                push_entry,
    input  logic                           queue_ready
);

    logic [gcs_pkg::POS_W-1:0] key_position_reg;
    logic [gcs_pkg::POS_W-1:0] key_position_next;
    logic [gcs_pkg::LEN_W-1:0] len_eff;
    logic [gcs_pkg::POS_W-1:0] pos_use;
    logic [gcs_pkg::LEN_W-1:0] pos_inc;
    logic [gcs_pkg::IDX_W:0]   lookup;

    assign in_ready = queue_ready;
    assign push     = in_valid && queue_ready;

    always_comb
    begin
        if (key_length == '0)
            len_eff = gcs_pkg::LEN_W'(1);
        else if (key_length > gcs_pkg::LEN_W'(MAX_KEY_DIGITS))
            len_eff = gcs_pkg::LEN_W'(MAX_KEY_DIGITS);
        else
            len_eff = key_length;

        // fall back to the first digit when the length shrank mid-message
        if ({1'b0, key_position_reg} >= len_eff)
            pos_use = '0;
        else
            pos_use = key_position_reg;

        pos_inc = {1'b0, pos_use} + gcs_pkg::LEN_W'(1);
        if (pos_inc >= len_eff || in_last)
            key_position_next = '0;
        else
            key_position_next = pos_inc[gcs_pkg::POS_W-1:0];

        lookup           = gcs_pkg::letter_index(in_code);
        push_entry.idx   = lookup[gcs_pkg::IDX_W-1:0];
        push_entry.bad   = lookup[gcs_pkg::IDX_W];
        push_entry.shift = key_digits[pos_use*gcs_pkg::DIGIT_W +: gcs_pkg::DIGIT_W];
        push_entry.eot   = in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_position_reg <= '0;
        else if (push)
            key_position_reg <= key_position_next;
    end

endmodule

// ===== hw/rtl/gcs_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on gcs_pkg.
module gcs_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  gcs_pkg::entry_t  push_entry,
    output logic             ready,
    input  logic             pop,
    output logic             not_empty,
    output gcs_pkg::entry_t  head
);

    gcs_pkg::entry_t                mem [gcs_pkg::QUEUE_DEPTH];
    logic [gcs_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [gcs_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [gcs_pkg::QCNT_W-1:0]     count_reg;
    logic [gcs_pkg::QCNT_W-1:0]     count_next;

    assign ready     = count_reg != gcs_pkg::QCNT_W'(gcs_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + gcs_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - gcs_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + gcs_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + gcs_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/gcs_back.sv =====
// Back end: applies the shift modulo 59, maps back to a character code and
// holds the result word in the output register. Depends on gcs_pkg.
module gcs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          mode,
    input  logic                          not_empty,
    input  gcs_pkg::entry_t               head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gcs_pkg::CHAR_W-1:0]    out_code,
    output logic                          out_bad,
    output logic                          out_last
);

    logic                          valid_reg;
    logic [gcs_pkg::CHAR_W-1:0]    code_reg;
    logic                          bad_reg;
    logic                          last_reg;
    logic [gcs_pkg::SUM_W-1:0]     sum;
    logic [gcs_pkg::SUM_W-1:0]     wrapped;
    logic [gcs_pkg::CHAR_W-1:0]    code_next;

    assign pop = not_empty && (!valid_reg || out_ready);

    always_comb
    begin
        if (mode)
            sum = {1'b0, head.idx} + gcs_pkg::ALPHA_SIZE
                - {{(gcs_pkg::SUM_W-gcs_pkg::DIGIT_W){1'b0}}, head.shift};
        else
            sum = {1'b0, head.idx}
                + {{(gcs_pkg::SUM_W-gcs_pkg::DIGIT_W){1'b0}}, head.shift};

        // sum stays below twice the alphabet size: one subtract suffices
        if (sum >= gcs_pkg::ALPHA_SIZE)
            wrapped = sum - gcs_pkg::ALPHA_SIZE;
        else
            wrapped = sum;

        if (head.bad)
            code_next = '0;
        else
            code_next = gcs_pkg::letter_code(wrapped[gcs_pkg::IDX_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            code_reg <= code_next;
            bad_reg  <= head.bad;
            last_reg <= head.eot;
        end
    end

    assign out_valid = valid_reg;
    assign out_code  = code_reg;
    assign out_bad   = bad_reg;
    assign out_last  = last_reg;

endmodule

// ===== hw/rtl/gronsfeld_cipher_stream.sv =====
// Top level of the Gronsfeld cipher stream: configuration registers, front
// end, queue and back end. Depends on gcs_pkg, gcs_front, gcs_queue, gcs_back.
//
// Usage:
//   s_* channel takes one character word: s_tdata is the 16-bit character
//   code, s_tlast marks the last character of a message.
//   m_* channel returns one word per character: m_tdata is the shifted code
//   (0 for a character outside the alphabet), m_tuser flags such a character,
//   m_tlast copies the input mark.
//   cfg_* channel writes key_digits (index 0), key_length (1) and mode (2);
//   cfg_ready is always high and other indexes are dropped. Write only while
//   no words are in flight.
//   An accepted word is written into the queue, then popped into the output
//   register. Throughput is one word per cycle while m_tready stays high; the
//   front-end lookup and key step and the back-end modulo add are combinational.
//   When m_tready is low the output register holds its word and the two-entry
//   queue absorbs up to two more words before s_tready drops.
//   Reset clears the queue, the output valid, the key position (first digit)
//   and loads key 1, length 1, encrypt mode.
module gronsfeld_cipher_stream #(
    parameter int unsigned MAX_KEY_DIGITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [15:0] char_code
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // [15:0] out_code
    output logic                                m_tuser,   // [0] bad_char
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gcs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gcs_pkg::KEY_W-1:0]           cfg_data
);

    logic [gcs_pkg::KEY_W-1:0] key_digits_reg;
    logic [gcs_pkg::LEN_W-1:0] key_length_reg;
    logic                      mode_reg;

    logic            push;
    logic            pop;
    logic            queue_ready;
    logic            queue_not_empty;
    gcs_pkg::entry_t push_entry;
    gcs_pkg::entry_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_digits_reg <= gcs_pkg::KEY_W'(1);
            key_length_reg <= gcs_pkg::LEN_W'(1);
            mode_reg       <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (gcs_pkg::cfg_reg_t'(cfg_index))
                gcs_pkg::REG_KEY_DIGITS: key_digits_reg <= cfg_data;
                gcs_pkg::REG_KEY_LENGTH: key_length_reg <= cfg_data[gcs_pkg::LEN_W-1:0];
                gcs_pkg::REG_MODE:       mode_reg       <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    gcs_front #(
        .MAX_KEY_DIGITS (MAX_KEY_DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_code     (s_tdata),
        .in_last     (s_tlast),
        .key_digits  (key_digits_reg),
        .key_length  (key_length_reg),
        .push        (push),
        .push_entry  (push_entry),
        .queue_ready (queue_ready)
    );

    gcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .ready      (queue_ready),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .head       (head)
    );

    gcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .not_empty (queue_not_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_code  (m_tdata),
        .out_bad   (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

// ===== hw/rtl/gcs_checker.sv =====
// Port-level checks for the Gronsfeld cipher stream, bound to the top level.
// Depends on gronsfeld_cipher_stream.
module gcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // hold a stalled word valid
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // hold a stalled word unchanged
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output word changed");

    // a flagged character carries code 0
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 16'h0000)
        else $error("bad character with nonzero code");

    // a good character maps into the alphabet
    a_good_letter: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            (m_tdata >= 16'h0061 && m_tdata <= 16'h007A) ||
            (m_tdata >= 16'h0410 && m_tdata <= 16'h042F) ||
            (m_tdata == 16'h0401))
        else $error("output code outside the alphabet");

endmodule

bind gronsfeld_cipher_stream gcs_checker u_gcs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== verif/gcs_cipher_checker.sv =====
// Scoreboard for the Gronsfeld cipher stream: tracks key registers and key
// position, predicts every output word and compares it. Depends on gcs_pkg.
`timescale 1ns / 1ps

module gcs_cipher_checker #(
    parameter int unsigned MAX_DIGITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] char_code
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [15:0]                   m_tdata,   // [15:0] out_code
    input  logic                          m_tuser,   // [0] bad_char
    input  logic                          m_tlast,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [gcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gcs_pkg::KEY_W-1:0]     cfg_data,
    output int                            mismatches,
    output int                            words_pending
);

    localparam int unsigned LETTERS = 59;

    typedef struct packed {
        logic [15:0] code;
        logic        bad;
        logic        last;
    } cipher_word_t;

    logic [15:0]  alphabet [0:LETTERS-1];
    logic [63:0]  key_digits_q;
    logic [4:0]   key_length_q;
    logic         decrypt_q;
    logic [3:0]   key_pos_q;
    cipher_word_t cipher_words [$];

    initial
    begin
        for (int i = 0; i < LETTERS; i++)
        begin
            if (i < 6)
                alphabet[i] = 16'h0410 + 16'(i);
            else if (i == 6)
                alphabet[i] = 16'h0401;
            else if (i < 33)
                alphabet[i] = 16'h0416 + 16'(i - 7);
            else
                alphabet[i] = 16'h0061 + 16'(i - 33);
        end
    end

    // Shift one character by the current key digit and advance the position
    task automatic encipher_char(input logic [15:0] code, input logic last);
        int unsigned  eff_len;
        int unsigned  pos;
        int unsigned  shift;
        int unsigned  idx;
        int unsigned  r;
        logic         found;
        cipher_word_t word;
        begin
            eff_len = {27'd0, key_length_q};
            if (eff_len == 0)
                eff_len = 1;
            if (eff_len > MAX_DIGITS)
                eff_len = MAX_DIGITS;
            pos = {28'd0, key_pos_q};
            if (pos >= eff_len)
                pos = 0;
            shift = {28'd0, key_digits_q[4*pos +: 4]};
            found = 1'b0;
            idx   = 0;
            for (int i = 0; i < LETTERS; i++)
            begin
                if (alphabet[i] == code)
                begin
                    found = 1'b1;
                    idx   = i;
                end
            end
            word.last = last;
            if (!found)
            begin
                word.code = 16'h0000;
                word.bad  = 1'b1;
            end
            else
            begin
                if (decrypt_q)
                    r = (idx + LETTERS - shift) % LETTERS;
                else
                    r = (idx + shift) % LETTERS;
                word.code = alphabet[r];
                word.bad  = 1'b0;
            end
            cipher_words.insert(cipher_words.size(), word);
            pos = pos + 1;
            if (pos >= eff_len || last)
                pos = 0;
            key_pos_q = pos[3:0];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cipher_word_t want;
        if (!rst_n)
        begin
            key_digits_q = 64'd1;
            key_length_q = 5'd1;
            decrypt_q    = 1'b0;
            key_pos_q    = 4'd0;
            mismatches   = 0;
            cipher_words.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (cipher_words.size() == 0)
                begin
                    $error("output word %h with no result expected", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = cipher_words.pop_front();
                    if (m_tdata !== want.code)
                    begin
                        $error("out_code: expected %h, got %h", want.code, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== want.bad)
                    begin
                        $error("bad_char: expected %b, got %b", want.bad, m_tuser);
                        mismatches++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("end_out: expected %b, got %b", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                encipher_char(s_tdata, s_tlast);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gcs_pkg::REG_KEY_DIGITS: key_digits_q = cfg_data;
                    gcs_pkg::REG_KEY_LENGTH: key_length_q = cfg_data[4:0];
                    gcs_pkg::REG_MODE:       decrypt_q    = cfg_data[0];
                    default: ;  // drop writes to unused indexes
                endcase
            end
        end
        words_pending = cipher_words.size();
    end

endmodule

// ===== verif/tb.sv =====
// Top of the Gronsfeld cipher stream testbench: clock, reset, stimulus,
// stalls and verdict. Depends on gcs_pkg, gronsfeld_cipher_stream, gcs_cipher_checker.
`timescale 1ns / 1ps

module tb;

    localparam logic [gcs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_CHARS   = 1350;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [63:0] KEY_ALL_NINES = 64'h9999_9999_9999_9999;
    localparam logic [63:0] KEY_ALL_F     = 64'hFFFF_FFFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] char_code
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] out_code
    logic        m_tuser;   // [0] bad_char
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [gcs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gcs_pkg::KEY_W-1:0]     cfg_data;

    int   mismatches;
    int   words_pending;
    int   idle_cycles;
    logic gaps_on;

    gronsfeld_cipher_stream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gcs_cipher_checker u_cipher_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                return 0;
            else if (r < 90)
                return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
    endfunction

    function automatic logic [15:0] random_char();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                return 16'h0410 + 16'($urandom_range(0, 31));
            else if (r < 50)
                return 16'h0401;
            else if (r < 80)
                return 16'h0061 + 16'($urandom_range(0, 25));
            else if (r < 88)
            begin
                // codes just outside the letter ranges, plus 0000 and FFFF
                case ($urandom_range(0, 7))
                    0: return 16'h0400;
                    1: return 16'h0402;
                    2: return 16'h040F;
                    3: return 16'h0430;
                    4: return 16'h0060;
                    5: return 16'h007B;
                    6: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            return 16'($urandom_range(0, 65535));
        end
    endfunction

    function automatic logic [63:0] random_key();
        logic [63:0] key;
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                for (int i = 0; i < 16; i++)
                    key[4*i +: 4] = 4'($urandom_range(0, 9));
            end
            else if (r < 76)
                key = KEY_ALL_NINES;
            else if (r < 82)
                key = 64'd0;
            else if (r < 88)
                key = KEY_ALL_F;
            else
                key = {$urandom, $urandom};
            return key;
        end
    endfunction

    function automatic logic [4:0] random_length();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                return 5'($urandom_range(1, 16));
            else if (r < 75)
                return 5'd16;
            else if (r < 83)
                return 5'd1;
            else if (r < 89)
                return 5'd0;
            return 5'($urandom_range(17, 31));
        end
    endfunction

    // Present one character and hold it until accepted
    task automatic send_char(input logic [15:0] code, input logic last);
        int gap;
        begin
            gap = gaps_on ? pick_gap() : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= code;
            s_tlast  <= last;
            do
                @(posedge clk);
            while (!s_tready);
            @(negedge clk);
        end
    endtask

    // Drop valid and wait for every word in flight to come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [gcs_pkg::CFG_IDX_W-1:0] index,
                             input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_message(input int length, input logic close);
        for (int i = 0; i < length; i++)
            send_char(random_char(), close && (i == length - 1));
    endtask

    // Random key setup between phases; junk in upper bits must be ignored
    task automatic setup_phase();
        logic [63:0] noise;
        int          order;
        begin
            wait_idle();
            noise = {$urandom, $urandom};
            order = $urandom_range(0, 1);
            if (order == 0)
                write_reg(gcs_pkg::REG_KEY_DIGITS, random_key());
            if ($urandom_range(0, 2) == 0)
                write_reg(gcs_pkg::REG_KEY_LENGTH, {noise[63:5], random_length()});
            else
                write_reg(gcs_pkg::REG_KEY_LENGTH, {59'd0, random_length()});
            if ($urandom_range(0, 2) == 0)
                write_reg(gcs_pkg::REG_MODE, {noise[63:1], 1'($urandom_range(0, 1))});
            else
                write_reg(gcs_pkg::REG_MODE, {63'd0, 1'($urandom_range(0, 1))});
            if (order == 1)
                write_reg(gcs_pkg::REG_KEY_DIGITS, random_key());
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_UNUSED, {$urandom, $urandom});
        end
    endtask

    // Stall the output side in bursts, with long stretches of no stall
    initial
    begin
        int run_len;
        int stall_len;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 9) < 7)
                run_len = $urandom_range(1, 8);
            else
                run_len = $urandom_range(30, 150);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:            stall_len = 0;
                8, 9, 10, 11, 12, 13, 14, 15, 16:  stall_len = $urandom_range(1, 3);
                default:                           stall_len = $urandom_range(5, 40);
            endcase
            @(negedge clk);
            m_tready <= 1'b1;
            repeat (run_len - 1) @(negedge clk);
            if (stall_len > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall_len - 1) @(negedge clk);
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int random_sent;
        int msg_count;
        int msg_len;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 16'h0000;
        s_tlast     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = gcs_pkg::REG_KEY_DIGITS;
        cfg_data    = 64'd0;
        gaps_on     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset key: shift by one, encrypt; range edges and wraparound
        send_char(16'h0410, 1'b0);
        send_char(16'h0401, 1'b0);
        send_char(16'h0415, 1'b0);
        send_char(16'h0416, 1'b0);
        send_char(16'h042F, 1'b0);
        send_char(16'h0061, 1'b0);
        send_char(16'h007A, 1'b0);
        send_char(16'h0400, 1'b0);
        send_char(16'h0402, 1'b0);
        send_char(16'h0430, 1'b0);
        send_char(16'h0060, 1'b0);
        send_char(16'h007B, 1'b0);
        send_char(16'h0000, 1'b0);
        send_char(16'hFFFF, 1'b1);

        // Nibbles above nine, full length, decrypt with wrap below zero
        wait_idle();
        write_reg(gcs_pkg::REG_KEY_DIGITS, KEY_ALL_F);
        write_reg(gcs_pkg::REG_KEY_LENGTH, 64'd16);
        write_reg(gcs_pkg::REG_MODE, 64'd1);
        send_char(16'h0410, 1'b0);
        send_char(16'h0401, 1'b0);
        send_char(16'h0061, 1'b1);

        // Length above the maximum, then cut to zero mid-message
        wait_idle();
        write_reg(gcs_pkg::REG_KEY_DIGITS, KEY_ALL_NINES);
        write_reg(gcs_pkg::REG_KEY_LENGTH, 64'd31);
        write_reg(gcs_pkg::REG_MODE, 64'd0);
        send_char(16'h007A, 1'b0);
        send_char(16'h042F, 1'b0);
        send_char(16'h0072, 1'b0);
        send_char(16'h0420, 1'b0);
        wait_idle();
        write_reg(gcs_pkg::REG_KEY_LENGTH, 64'd0);
        write_reg(REG_UNUSED, KEY_ALL_F);
        send_char(16'h0070, 1'b0);
        send_char(16'h0411, 1'b1);
        wait_idle();
        write_reg(gcs_pkg::REG_KEY_DIGITS, 64'd0);
        send_char(16'h0401, 1'b1);

        random_sent = 0;
        while (random_sent < RANDOM_CHARS)
        begin
            setup_phase();
            gaps_on   = ($urandom_range(0, 3) != 0);
            msg_count = $urandom_range(2, 8);
            for (int m = 0; m < msg_count; m++)
            begin
                if ($urandom_range(0, 9) == 0)
                    msg_len = $urandom_range(25, 60);
                else
                    msg_len = $urandom_range(1, 24);
                // leave the last message open now and then so the key
                // position carries over into the next setup
                send_message(msg_len,
                             !(m == msg_count - 1 && $urandom_range(0, 2) == 0));
                random_sent += msg_len;
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
